[rtl/core/flight_event_detector_top_macros.svh]
// ---------------------------------------------------------------------------
// Flight event detector assertion macros
// Shared forms for the concurrent checks of the flight event detector.
// ---------------------------------------------------------------------------
`ifndef FLIGHT_EVENT_DETECTOR_TOP_MACROS_SVH
`define FLIGHT_EVENT_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define FED_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define FED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/fed_pkg.sv]
// ---------------------------------------------------------------------------
// Flight event detector package
// Shared types, codes and constants of the flight event detector.
// ---------------------------------------------------------------------------
package fed_pkg;

  // Default width of altitude and speed values.
  localparam int VALUE_WIDTH_DEF = 24;

  // Fixed field widths.
  localparam int DT_W     = 16;
  localparam int KIND_W   = 3;
  localparam int WEIGHT_W = 8;
  localparam int SDA_W    = 23;
  localparam int CNT_W    = 8;
  localparam int SCALE_W  = 10;

  // Configuration port.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_ALT_WEIGHT   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SPD_WEIGHT   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_ALT   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_EARLY_DEPLOY = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MARGIN       = 3'd4;

  // Register reset values.
  localparam logic [WEIGHT_W-1:0] ALT_WEIGHT_RST = 8'd128;
  localparam logic [WEIGHT_W-1:0] SPD_WEIGHT_RST = 8'd128;
  localparam logic [SDA_W-1:0]    SECOND_ALT_RST = 23'd1600;
  localparam logic [CNT_W-1:0]    MARGIN_RST     = 8'd5;

  // Check selector codes.
  localparam logic [KIND_W-1:0] KIND_LAUNCH  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_APOGEE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SECOND  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LANDING = 3'd3;

  // Thresholds in 1/16 units and the speed scale.
  localparam int LAUNCH_ALT         = 320;
  localparam int APOGEE_SPEED       = -16;
  localparam int EARLY_APOGEE_SPEED = 160;
  localparam int LANDING_SPEED      = 32;
  localparam int SPEED_SCALE        = 1000;

  // Configuration register file contents.
  typedef struct packed {
    logic [WEIGHT_W-1:0] alt_weight;
    logic [WEIGHT_W-1:0] spd_weight;
    logic [SDA_W-1:0]    second_alt;
    logic                early_deploy;
    logic [CNT_W-1:0]    margin;
  } fed_cfg_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_ALT,
    S_DIFF,
    S_DIV,
    S_SAT,
    S_SPD,
    S_DONE
  } fed_state_t;

endpackage

[rtl/core/fed_in_if.sv]
// ---------------------------------------------------------------------------
// Flight event detector sample channel
// Valid/ready channel carrying one altitude sample word.
// ---------------------------------------------------------------------------
interface fed_in_if
  import fed_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) ();

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] raw_altitude;
  logic [DT_W-1:0]               elapsed_ms;
  logic [KIND_W-1:0]             kind;

  modport source (output valid, raw_altitude, elapsed_ms, kind, input ready);
  modport sink (input valid, raw_altitude, elapsed_ms, kind, output ready);

endinterface

[rtl/core/fed_out_if.sv]
// ---------------------------------------------------------------------------
// Flight event detector result channel
// Valid/ready channel carrying one result word per sample.
// ---------------------------------------------------------------------------
interface fed_out_if
  import fed_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) ();

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] smoothed_altitude;
  logic signed [VALUE_WIDTH-1:0] vertical_speed;
  logic signed [VALUE_WIDTH-1:0] peak_altitude;
  logic signed [VALUE_WIDTH-1:0] peak_speed;
  logic                          event_detected;

  modport source (output valid, smoothed_altitude, vertical_speed, peak_altitude,
                  peak_speed, event_detected, input ready);
  modport sink (input valid, smoothed_altitude, vertical_speed, peak_altitude,
                peak_speed, event_detected, output ready);

endinterface

[rtl/core/fed_cfg.sv]
// ---------------------------------------------------------------------------
// Flight event detector configuration registers
// APB-style register file holding weights, thresholds and the margin.
// ---------------------------------------------------------------------------
module fed_cfg
  import fed_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output fed_cfg_t              cfg
);

  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alt_weight   <= ALT_WEIGHT_RST;
      cfg.spd_weight   <= SPD_WEIGHT_RST;
      cfg.second_alt   <= SECOND_ALT_RST;
      cfg.early_deploy <= 1'b0;
      cfg.margin       <= MARGIN_RST;
    end else if (wr_en) begin
      case (idx)
        REG_ALT_WEIGHT:   cfg.alt_weight   <= pwdata[WEIGHT_W-1:0];
        REG_SPD_WEIGHT:   cfg.spd_weight   <= pwdata[WEIGHT_W-1:0];
        REG_SECOND_ALT:   cfg.second_alt   <= pwdata[SDA_W-1:0];
        REG_EARLY_DEPLOY: cfg.early_deploy <= pwdata[0];
        REG_MARGIN:       cfg.margin       <= pwdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (idx)
      REG_ALT_WEIGHT:   prdata = CFG_DATA_W'(cfg.alt_weight);
      REG_SPD_WEIGHT:   prdata = CFG_DATA_W'(cfg.spd_weight);
      REG_SECOND_ALT:   prdata = CFG_DATA_W'(cfg.second_alt);
      REG_EARLY_DEPLOY: prdata = CFG_DATA_W'(cfg.early_deploy);
      REG_MARGIN:       prdata = CFG_DATA_W'(cfg.margin);
      default:          prdata = '0;
    endcase
  end

endmodule

[rtl/core/fed_smooth.sv]
// ---------------------------------------------------------------------------
// Flight event detector smoothing unit
// Shared Q0.8 exponential mix with round-half-up, used for altitude and speed.
// ---------------------------------------------------------------------------
module fed_smooth
  import fed_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic [WEIGHT_W-1:0]           weight,
  input  logic signed [VALUE_WIDTH-1:0] old_value,
  input  logic signed [VALUE_WIDTH-1:0] sample,
  output logic signed [VALUE_WIDTH-1:0] result
);

  localparam int AW = VALUE_WIDTH + 11;

  logic signed [VALUE_WIDTH:0] delta;
  logic signed [AW-1:0]        w_ext;
  logic signed [AW-1:0]        d_ext;
  logic signed [AW-1:0]        s_ext;
  logic signed [AW-1:0]        acc;

  // w*old + (256-w)*sample is rewritten as 256*sample + w*(old-sample),
  // so a single multiplier serves.
  assign delta = {old_value[VALUE_WIDTH-1], old_value} - {sample[VALUE_WIDTH-1], sample};
  assign w_ext = {{(AW-WEIGHT_W){1'b0}}, weight};
  assign d_ext = {{(AW-VALUE_WIDTH-1){delta[VALUE_WIDTH]}}, delta};
  assign s_ext = {{3{sample[VALUE_WIDTH-1]}}, sample, 8'd0};
  assign acc   = s_ext + w_ext * d_ext + AW'(128);

  // A convex mix always lands back in range.
  assign result = acc[VALUE_WIDTH+7:8];

endmodule

[rtl/core/fed_div.sv]
// ---------------------------------------------------------------------------
// Flight event detector serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module fed_div
  import fed_pkg::*;
#(
  parameter int NUM_W = VALUE_WIDTH_DEF + SCALE_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DT_W-1:0]  den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  quo_sh;
  logic [DT_W-1:0]   rem;
  logic [DT_W-1:0]   den_q;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [DT_W:0]     trial;
  logic [DT_W:0]     trial_sub;
  logic              fits;

  // One restoring step: bring down the next numerator bit and try a subtract.
  assign trial     = {rem, quo_sh[NUM_W-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign fits      = trial >= {1'b0, den_q};
  assign quo       = quo_sh;

  // Step control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(NUM_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient and remainder shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_sh <= num;
      rem    <= '0;
      den_q  <= den;
    end else if (busy) begin
      quo_sh <= {quo_sh[NUM_W-2:0], fits};
      rem    <= fits ? trial_sub[DT_W-1:0] : trial[DT_W-1:0];
    end
  end

endmodule

[rtl/core/flight_event_detector_top.sv]
// A sample is accepted only in S_IDLE, then passes S_ALT, S_DIFF, S_DIV, S_SAT, S_SPD
// and S_DONE before another is taken; S_DONE holds while an unread result waits. The
// serial divider in S_DIV makes one quotient bit per cycle over VALUE_WIDTH + 10 bits.
// A finished result waits in an output register while the next sample is taken.
// Reset (rst, synchronous, active high) clears filters, peaks, the pass count
// and the registers to their defaults.
// ---------------------------------------------------------------------------
// Flight event detector top level
// Smooths altitude and speed, tracks peaks and qualifies flight events.
// ---------------------------------------------------------------------------
`include "flight_event_detector_top_macros.svh"

module flight_event_detector_top
  import fed_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  fed_in_if.sink                samples,
  fed_out_if.source             results,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int VW    = VALUE_WIDTH;
  localparam int NUM_W = VW + SCALE_W;
  localparam int CMP_W = 33;

  localparam logic signed [VW-1:0] VAL_HI = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VAL_LO = {1'b1, {(VW-1){1'b0}}};
  localparam logic [NUM_W-1:0] QUO_HI = {{(NUM_W-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] TH_LAUNCH  = VW'(LAUNCH_ALT);
  localparam logic signed [VW-1:0] TH_APOGEE  = VW'(APOGEE_SPEED);
  localparam logic signed [VW-1:0] TH_EARLY   = VW'(EARLY_APOGEE_SPEED);
  localparam logic signed [VW-1:0] TH_LAND_HI = VW'(LANDING_SPEED);
  localparam logic signed [VW-1:0] TH_LAND_LO = VW'(-LANDING_SPEED);

  fed_cfg_t   cfg;
  fed_state_t state, state_next;

  // Filter state.
  logic signed [VW-1:0] alt_filter;
  logic signed [VW-1:0] spd_filter;
  logic signed [VW-1:0] alt_peak;
  logic signed [VW-1:0] spd_peak;
  logic [CNT_W-1:0]     pass_count;

  // Per-sample working registers.
  logic signed [VW-1:0] raw_q;
  logic [DT_W-1:0]      dt_q;
  logic [KIND_W-1:0]    kind_q;
  logic signed [VW-1:0] new_alt;
  logic signed [VW-1:0] new_spd;
  logic signed [VW-1:0] spd_sample;
  logic                 diff_neg;

  // Output register.
  logic                 res_valid;
  logic signed [VW-1:0] res_alt;
  logic signed [VW-1:0] res_spd;
  logic signed [VW-1:0] res_alt_peak;
  logic signed [VW-1:0] res_spd_peak;
  logic                 res_event;

  // Sequencer outputs.
  logic in_take;
  logic sel_speed;
  logic div_start;
  logic out_load;

  // Shared units.
  logic [WEIGHT_W-1:0]  sm_weight;
  logic signed [VW-1:0] sm_old;
  logic signed [VW-1:0] sm_sample;
  logic signed [VW-1:0] sm_result;
  logic                 div_done;
  logic [NUM_W-1:0]     div_quo;

  // Datapath intermediates.
  logic signed [VW:0]   diff;
  logic [VW-1:0]        mag;
  logic [NUM_W-1:0]     div_num;
  logic signed [VW-1:0] sat_q;
  logic signed [VW-1:0] alt_peak_next;
  logic signed [VW-1:0] spd_peak_next;
  logic [CNT_W-1:0]     cnt_inc;
  logic [CNT_W-1:0]     pass_count_next;
  logic                 pass;
  logic                 checked;
  logic                 event_next;

  fed_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The smoothing unit serves altitude first, then speed.
  assign sm_weight = sel_speed ? cfg.spd_weight : cfg.alt_weight;
  assign sm_old    = sel_speed ? spd_filter : alt_filter;
  assign sm_sample = sel_speed ? spd_sample : raw_q;

  fed_smooth #(.VALUE_WIDTH(VW)) u_smooth (
    .weight    (sm_weight),
    .old_value (sm_old),
    .sample    (sm_sample),
    .result    (sm_result)
  );

  // Altitude change magnitude, scaled by SPEED_SCALE for the millisecond interval.
  assign diff    = {new_alt[VW-1], new_alt} - {alt_filter[VW-1], alt_filter};
  assign mag     = diff[VW] ? VW'(-diff) : diff[VW-1:0];
  assign div_num = NUM_W'(mag) * NUM_W'(SPEED_SCALE);

  fed_div #(.NUM_W(NUM_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (dt_q),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Restore the sign and saturate the raw speed.
  always_comb begin
    if (!diff_neg) begin
      sat_q = (div_quo > QUO_HI) ? VAL_HI : div_quo[VW-1:0];
    end else begin
      sat_q = (div_quo > QUO_HI) ? VAL_LO : -div_quo[VW-1:0];
    end
  end

  // Peak tracking on the new smoothed values.
  assign alt_peak_next = (new_alt > alt_peak) ? new_alt : alt_peak;
  assign spd_peak_next = (new_spd > spd_peak) ? new_spd : spd_peak;

  // Selected flight check.
  always_comb begin
    pass    = 1'b0;
    checked = 1'b1;
    case (kind_q)
      KIND_LAUNCH:  pass = new_alt > TH_LAUNCH;
      KIND_APOGEE:  pass = (new_spd < TH_APOGEE) || (cfg.early_deploy && (new_spd < TH_EARLY));
      KIND_SECOND:  pass = $signed(CMP_W'(new_alt)) < $signed({10'd0, cfg.second_alt});
      KIND_LANDING: pass = (new_spd < TH_LAND_HI) && (new_spd > TH_LAND_LO);
      default:      checked = 1'b0;
    endcase
  end

  // Pass counter: saturating count, clears on a fail or when the event fires.
  assign cnt_inc = (pass_count == {CNT_W{1'b1}}) ? pass_count : pass_count + CNT_W'(1);

  always_comb begin
    pass_count_next = pass_count;
    event_next      = 1'b0;
    if (checked) begin
      if (pass) begin
        if (cnt_inc > cfg.margin) begin
          pass_count_next = '0;
          event_next      = 1'b1;
        end else begin
          pass_count_next = cnt_inc;
        end
      end else begin
        pass_count_next = '0;
      end
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (samples.valid) state_next = S_ALT;
      end
      S_ALT:  state_next = S_DIFF;
      S_DIFF: state_next = S_DIV;
      S_DIV: begin
        if (div_done) state_next = S_SAT;
      end
      S_SAT:  state_next = S_SPD;
      S_SPD:  state_next = S_DONE;
      S_DONE: begin
        if (!res_valid || results.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_take   = 1'b0;
    sel_speed = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      S_IDLE: in_take = 1'b1;
      S_DIFF: div_start = 1'b1;
      S_SPD:  sel_speed = 1'b1;
      S_DONE: out_load = !res_valid || results.ready;
      default: begin
      end
    endcase
  end

  assign samples.ready = in_take;

  // Working registers.
  always_ff @(posedge clk) begin
    if (in_take && samples.valid) begin
      raw_q  <= samples.raw_altitude;
      dt_q   <= (samples.elapsed_ms == '0) ? DT_W'(1) : samples.elapsed_ms;
      kind_q <= samples.kind;
    end
    if (state == S_ALT) begin
      new_alt <= sm_result;
    end
    if (state == S_DIFF) begin
      diff_neg <= diff[VW];
    end
    if (state == S_SAT) begin
      spd_sample <= sat_q;
    end
    if (state == S_SPD) begin
      new_spd <= sm_result;
    end
  end

  // Filter state commits together with the result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      alt_filter <= '0;
      spd_filter <= '0;
      alt_peak   <= '0;
      spd_peak   <= '0;
      pass_count <= '0;
    end else if (out_load) begin
      alt_filter <= new_alt;
      spd_filter <= new_spd;
      alt_peak   <= alt_peak_next;
      spd_peak   <= spd_peak_next;
      pass_count <= pass_count_next;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      res_alt      <= new_alt;
      res_spd      <= new_spd;
      res_alt_peak <= alt_peak_next;
      res_spd_peak <= spd_peak_next;
      res_event    <= event_next;
    end
  end

  assign results.valid             = res_valid;
  assign results.smoothed_altitude = res_alt;
  assign results.vertical_speed    = res_spd;
  assign results.peak_altitude     = res_alt_peak;
  assign results.peak_speed        = res_spd_peak;
  assign results.event_detected    = res_event;

  // A waiting result word is never overwritten.
  `FED_ASSERT_IMPLY(a_no_overwrite, out_load, !res_valid || results.ready, "result overwritten")
  // The divider only finishes while the sequencer waits for it.
  `FED_ASSERT_IMPLY(a_div_done_state, div_done, state == S_DIV, "divider done out of step")
  // A qualified event always leaves the pass counter cleared.
  `FED_ASSERT_NEXT(a_event_clears, out_load && event_next, pass_count == '0, "count not cleared")
  // An accepted sample starts the altitude smoothing step.
  `FED_ASSERT_NEXT(a_accept_starts, samples.valid && samples.ready, state == S_ALT,
    "accept did not start")

endmodule
